// File: src/bpfa_pkg.sv
// Shared definitions for the bitmap page frame allocator.
// Operation and status codes, field widths and the map row width.
// No dependencies.

package bpfa_pkg;

   // Pages held in one map row
   localparam int MAP_GRAIN = 8;

   // Field widths
   localparam int FUNC_W   = 3;
   localparam int PAGE_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REQUEST   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOCK      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_UNRESERVE = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   // Reset value of the total page register
   localparam logic [COUNT_W-1:0] TOTAL_RESET = 17'd65536;

endpackage

// File: src/bpfa_map.sv
// Page map storage: one bit per page, MAP_GRAIN pages per row.
// One write port and one read port with registered read data.
// Depends on bpfa_pkg.

module bpfa_map #(
   parameter int ROWS = 8192,
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [bpfa_pkg::MAP_GRAIN-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [bpfa_pkg::MAP_GRAIN-1:0] rd_data
);

   logic [bpfa_pkg::MAP_GRAIN-1:0] mem [ROWS];
   logic [bpfa_pkg::MAP_GRAIN-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data valid the cycle after the address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator: one map bit per page, run and request
// operations under a small sequencer. Depends on bpfa_pkg and bpfa_map.
//
// Sequencing: one operation is in flight at a time; req_tready is high
// only while the sequencer is idle. A request reads one map row of eight
// pages at a time, starting at the search hint, with a read state and a
// check state per row. Free, lock, reserve and unreserve do a
// read-modify-write of the map row for each page, with a read state and a
// check state per page, and a run stops early when it leaves the map.
// Init and reset both clear all ceil(NUM_PAGES / 8) rows of the map one
// row per cycle (8192 rows for the default size); after reset no transfer
// is accepted until that pass ends, while csr writes are taken at any time.
// A finished result sits in the output register and the next request can
// be accepted while it waits.

module bitmap_page_frame_allocator_unit #(
   parameter int NUM_PAGES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: total_pages
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // first_page[15:0], page_count[32:16], zero fill
   input  logic [2:0]  req_tuser,  // func[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // granted_page[15:0], free_pages[32:16],
                                   // used_pages[49:33], reserved_pages[66:50], zero fill
   output logic [2:0]  rsp_tuser   // granted[0], status[2:1]
);

   localparam int GRAIN = bpfa_pkg::MAP_GRAIN;
   localparam int CW    = bpfa_pkg::COUNT_W;
   localparam int ROWS  = (NUM_PAGES + GRAIN - 1) / GRAIN;
   localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int NPW   = $clog2(NUM_PAGES + 1);
   localparam int BW    = (NPW > 18) ? NPW : 18;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLEAR    = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CHK = 3'd3;
   localparam logic [2:0] S_RUN_RD   = 3'd4;
   localparam logic [2:0] S_RUN_CHK  = 3'd5;
   localparam logic [2:0] S_OUT      = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic                       clr_rsp_ff, clr_rsp_in;
   logic [bpfa_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [BW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [BW-1:0]              hint_ff, hint_in;
   logic [CW-1:0]              free_ff, free_in;
   logic [CW-1:0]              used_ff, used_in;
   logic [CW-1:0]              resv_ff, resv_in;
   logic [CW-1:0]              total_ff;
   logic [bpfa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                       granted_ff, granted_in;
   logic [bpfa_pkg::PAGE_W-1:0] gpage_ff, gpage_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bpfa_pkg::PAGE_W-1:0] rsp_page_ff;
   logic                       rsp_granted_ff;
   logic [bpfa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CW-1:0]              rsp_free_ff, rsp_used_ff, rsp_resv_ff;
   logic                       rsp_load;

   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_waddr, mem_raddr;
   logic [GRAIN-1:0]           mem_wdata, mem_rdata;

   logic [14:0]                tot_rows;
   logic [17:0]                bound_raw;
   logic [BW-1:0]              bound;
   logic                       req_xfer;

   // map bound: (total div 8 + 1) * 8, capped at the map size
   always_comb begin
      tot_rows  = {1'b0, total_ff[CW-1:3]} + 15'd1;
      bound_raw = {tot_rows, 3'b000};
      if (BW'(bound_raw) > BW'(NUM_PAGES)) begin
         bound = BW'(NUM_PAGES);
      end else begin
         bound = BW'(bound_raw);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= bpfa_pkg::TOTAL_RESET;
      end else if (csr_we) begin
         total_ff <= csr_wdata;
      end
   end

   // sequencer
   always_comb begin
      logic [BW-1:0]    row_base;
      logic [BW-1:0]    next_base;
      logic [GRAIN-1:0] lim_mask;
      logic [GRAIN-1:0] cand;
      logic [2:0]       off;
      logic [2:0]       hit_j;
      logic             hit;
      logic             bit_set;
      logic             set_op;
      logic [GRAIN-1:0] bit_mask;

      state_in   = state_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      func_in    = func_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      hint_in    = hint_ff;
      free_in    = free_ff;
      used_in    = used_ff;
      resv_in    = resv_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      gpage_in   = gpage_ff;

      mem_we    = 1'b0;
      mem_waddr = AW'(idx_ff >> 3);
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = AW'(idx_ff >> 3);

      // scan row decode
      row_base  = {hint_ff[BW-1:3], 3'b000};
      next_base = row_base + BW'(GRAIN);
      off       = hint_ff[2:0];
      if (next_base <= bound) begin
         lim_mask = '1;
      end else begin
         lim_mask = GRAIN'((9'd1 << bound[2:0]) - 9'd1);
      end
      cand  = ~mem_rdata & lim_mask & GRAIN'(8'hFF << off);
      hit   = 1'b0;
      hit_j = 3'd0;
      for (int j = GRAIN - 1; j >= 0; j--) begin
         if (cand[j]) begin
            hit   = 1'b1;
            hit_j = 3'(j);
         end
      end

      // run page decode
      bit_set  = mem_rdata[idx_ff[2:0]];
      bit_mask = GRAIN'(8'd1 << idx_ff[2:0]);
      set_op   = (func_ff == bpfa_pkg::FUNC_LOCK) || (func_ff == bpfa_pkg::FUNC_RESERVE);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               func_in    = req_tuser;
               idx_in     = BW'(req_tdata[15:0]);
               cnt_in     = req_tdata[32:16];
               status_in  = bpfa_pkg::STATUS_OK;
               granted_in = 1'b0;
               gpage_in   = '0;
               case (req_tuser)
                  bpfa_pkg::FUNC_INIT: begin
                     free_in    = total_ff;
                     used_in    = '0;
                     resv_in    = '0;
                     hint_in    = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  bpfa_pkg::FUNC_REQUEST: state_in = S_SCAN_RD;
                  bpfa_pkg::FUNC_FREE,
                  bpfa_pkg::FUNC_LOCK,
                  bpfa_pkg::FUNC_RESERVE,
                  bpfa_pkg::FUNC_UNRESERVE: state_in = S_RUN_RD;
                  default: state_in = S_OUT;
               endcase
            end
         end

         // zero the map one row per cycle
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = clr_rsp_ff ? S_OUT : S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         S_SCAN_RD: begin
            if (hint_ff >= bound) begin
               status_in = bpfa_pkg::STATUS_NOFREE;
               state_in  = S_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = AW'(hint_ff >> 3);
               state_in  = S_SCAN_CHK;
            end
         end

         // first clear bit at or above the hint within this row
         S_SCAN_CHK: begin
            if (hit) begin
               mem_we     = 1'b1;
               mem_waddr  = AW'(hint_ff >> 3);
               mem_wdata  = mem_rdata | GRAIN'(8'd1 << hit_j);
               hint_in    = {hint_ff[BW-1:3], hit_j};
               free_in    = free_ff - CW'(1);
               used_in    = used_ff + CW'(1);
               granted_in = 1'b1;
               gpage_in   = bpfa_pkg::PAGE_W'({hint_ff[BW-1:3], hit_j});
               status_in  = bpfa_pkg::STATUS_OK;
               state_in   = S_OUT;
            end else if (next_base >= bound) begin
               hint_in   = bound;
               status_in = bpfa_pkg::STATUS_NOFREE;
               state_in  = S_OUT;
            end else begin
               hint_in  = next_base;
               state_in = S_SCAN_RD;
            end
         end

         S_RUN_RD: begin
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end else if (idx_ff >= bound) begin
               status_in = bpfa_pkg::STATUS_RANGE;
               state_in  = S_OUT;
            end else begin
               mem_re   = 1'b1;
               state_in = S_RUN_CHK;
            end
         end

         // read-modify-write of one page, skipped if already in target state
         S_RUN_CHK: begin
            if (set_op && !bit_set) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata | bit_mask;
               free_in   = free_ff - CW'(1);
               if (func_ff == bpfa_pkg::FUNC_LOCK) begin
                  used_in = used_ff + CW'(1);
               end else begin
                  resv_in = resv_ff + CW'(1);
               end
            end else if (!set_op && bit_set) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata & ~bit_mask;
               free_in   = free_ff + CW'(1);
               if (func_ff == bpfa_pkg::FUNC_FREE) begin
                  used_in = used_ff - CW'(1);
               end else begin
                  resv_in = resv_ff - CW'(1);
               end
               if (hint_ff > idx_ff) begin
                  hint_in = idx_ff;
               end
            end
            idx_in   = idx_ff + BW'(1);
            cnt_in   = cnt_ff - CW'(1);
            state_in = S_RUN_RD;
         end

         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         hint_ff    <= '0;
         free_ff    <= '0;
         used_ff    <= '0;
         resv_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         hint_ff    <= hint_in;
         free_ff    <= free_in;
         used_ff    <= used_in;
         resv_ff    <= resv_in;
      end
   end

   // operation payload registers
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      gpage_ff   <= gpage_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_page_ff    <= gpage_ff;
         rsp_granted_ff <= granted_ff;
         rsp_status_ff  <= status_ff;
         rsp_free_ff    <= free_ff;
         rsp_used_ff    <= used_ff;
         rsp_resv_ff    <= resv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_resv_ff, rsp_used_ff, rsp_free_ff, rsp_page_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_granted_ff};

   bpfa_map #(
      .ROWS (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for bitmap_page_frame_allocator_unit.
// Holds a bit-accurate allocator predictor, a directed table and random phases.
// Depends on bpfa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_top;

   localparam int          NUM_PAGES   = 65536;
   localparam int          STALL_LIMIT = 600000;  // cycles with no transfer
   localparam int          HOLD_LEN    = 400;     // long receiver hold-off
   localparam logic [2:0]  FUNC_SPARE6 = 3'd6;    // unused codes, act as no-ops
   localparam logic [2:0]  FUNC_SPARE7 = 3'd7;

   typedef struct packed {
      logic [bpfa_pkg::PAGE_W-1:0]   page;
      logic                          granted;
      logic [bpfa_pkg::STATUS_W-1:0] status;
      logic [bpfa_pkg::COUNT_W-1:0]  free_pages;
      logic [bpfa_pkg::COUNT_W-1:0]  used_pages;
      logic [bpfa_pkg::COUNT_W-1:0]  reserved_pages;
   } alloc_result_type;

   // one directed row: either a total_pages write or an operation
   typedef struct packed {
      logic                          is_cfg;
      logic [bpfa_pkg::COUNT_W-1:0]  total;
      logic [bpfa_pkg::FUNC_W-1:0]   func;
      logic [bpfa_pkg::PAGE_W-1:0]   first;
      logic [bpfa_pkg::COUNT_W-1:0]  count;
      logic                          typed;
      alloc_result_type              want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [16:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // first_page[15:0], page_count[32:16], zero fill
   logic [2:0]  req_tuser;   // func[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // granted_page[15:0], free[32:16], used[49:33], reserved[66:50]
   logic [2:0]  rsp_tuser;   // granted[0], status[2:1]

   // predictor state
   bit   [NUM_PAGES-1:0]         frame_map;
   logic [bpfa_pkg::COUNT_W-1:0] scan_hint;
   logic [bpfa_pkg::COUNT_W-1:0] free_cnt;
   logic [bpfa_pkg::COUNT_W-1:0] used_cnt;
   logic [bpfa_pkg::COUNT_W-1:0] reserved_cnt;
   logic [bpfa_pkg::COUNT_W-1:0] total_cfg;

   alloc_result_type alloc_result_q[$];
   stim_row_type     directed_rows [23];
   int               mismatch_count;
   int               result_index;
   int               hold_asks;
   bit               idle_on;

   bitmap_page_frame_allocator_unit #(.NUM_PAGES(NUM_PAGES)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // map bound: (total div 8 + 1) * 8, capped at the map size
   function automatic logic [bpfa_pkg::COUNT_W-1:0] map_bound();
      logic [17:0] b;
      b = (18'(total_cfg >> 3) + 18'd1) << 3;
      if (b > 18'(NUM_PAGES))
         b = 18'(NUM_PAGES);
      return 17'(b);
   endfunction

   // set or clear one page; pages already in the target state are skipped
   function automatic void touch_page(input logic [2:0] fn, input logic [15:0] pg);
      if (fn == bpfa_pkg::FUNC_LOCK || fn == bpfa_pkg::FUNC_RESERVE) begin
         if (frame_map[pg])
            return;
         frame_map[pg] = 1'b1;
         free_cnt = free_cnt - 17'd1;
         if (fn == bpfa_pkg::FUNC_LOCK)
            used_cnt = used_cnt + 17'd1;
         else
            reserved_cnt = reserved_cnt + 17'd1;
      end else begin
         if (!frame_map[pg])
            return;
         frame_map[pg] = 1'b0;
         free_cnt = free_cnt + 17'd1;
         if (fn == bpfa_pkg::FUNC_FREE)
            used_cnt = used_cnt - 17'd1;
         else
            reserved_cnt = reserved_cnt - 17'd1;
         if (scan_hint > {1'b0, pg})
            scan_hint = {1'b0, pg};
      end
   endfunction

   // apply one operation to the predictor and return its result
   function automatic alloc_result_type run_allocator_op(input logic [2:0] fn,
                                                         input logic [15:0] fp,
                                                         input logic [16:0] cnt);
      alloc_result_type res;
      logic [16:0]      bnd;
      logic [17:0]      i;
      logic [17:0]      idx;
      res = '0;
      bnd = map_bound();
      case (fn)
         bpfa_pkg::FUNC_INIT: begin
            frame_map    = '0;
            free_cnt     = total_cfg;
            used_cnt     = '0;
            reserved_cnt = '0;
            scan_hint    = '0;
         end
         bpfa_pkg::FUNC_REQUEST: begin
            res.status = bpfa_pkg::STATUS_NOFREE;
            while (scan_hint < bnd) begin
               if (!frame_map[scan_hint[15:0]]) begin
                  touch_page(bpfa_pkg::FUNC_LOCK, scan_hint[15:0]);
                  res.page    = scan_hint[15:0];
                  res.granted = 1'b1;
                  res.status  = bpfa_pkg::STATUS_OK;
                  break;
               end
               scan_hint = scan_hint + 17'd1;
            end
         end
         bpfa_pkg::FUNC_FREE, bpfa_pkg::FUNC_LOCK,
         bpfa_pkg::FUNC_RESERVE, bpfa_pkg::FUNC_UNRESERVE: begin
            for (i = '0; i < 18'(cnt); i = i + 18'd1) begin
               idx = 18'(fp) + i;
               if (idx >= 18'(bnd)) begin
                  res.status = bpfa_pkg::STATUS_RANGE;
                  break;
               end
               touch_page(fn, idx[15:0]);
            end
         end
         default: ;
      endcase
      res.free_pages     = free_cnt;
      res.used_pages     = used_cnt;
      res.reserved_pages = reserved_cnt;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // offer one operation until accepted, then queue what it must return
   task automatic offer_op(input logic [2:0] fn, input logic [15:0] fp,
                           input logic [16:0] cnt, input logic typed,
                           input alloc_result_type want);
      alloc_result_type predicted;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = fn;
      req_tdata  = {7'd0, cnt, fp};
      do @(posedge clock); while (!req_tready);
      predicted = run_allocator_op(fn, fp, cnt);
      alloc_result_q.push_back(typed ? want : predicted);
   endtask

   // stop offering and wait until every queued result has come back
   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (alloc_result_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // total_pages is only written with the block idle
   task automatic write_total(input logic [16:0] v);
      wait_all_results();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      total_cfg = v;
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         $display("mismatch in %s: got 0x%0h, expected 0x%0h (result %0d)",
                  what, got, want, result_index);
         mismatch_count++;
      end
   endtask

   // result monitor and no-progress watchdog
   initial begin
      alloc_result_type want;
      int               stall_cycles;
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (alloc_result_q.size() == 0) begin
               check_field("unexpected result", 32'(rsp_tdata[15:0]), 32'hFFFF_FFFF);
            end else begin
               want = alloc_result_q.pop_front();
               check_field("granted_page", 32'(rsp_tdata[15:0]), 32'(want.page));
               check_field("granted", 32'(rsp_tuser[0]), 32'(want.granted));
               check_field("status", 32'(rsp_tuser[2:1]), 32'(want.status));
               check_field("free_pages", 32'(rsp_tdata[32:16]), 32'(want.free_pages));
               check_field("used_pages", 32'(rsp_tdata[49:33]), 32'(want.used_pages));
               check_field("reserved_pages", 32'(rsp_tdata[66:50]),
                           32'(want.reserved_pages));
            end
            result_index++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side ready: random stall bursts while idling is on, plus a long hold-off on demand
   initial begin
      int burst_left;
      int hold_left;
      int hold_seen;
      burst_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (!idle_on) begin
            rsp_tready = 1'b1;
         end else if (burst_left > 0) begin
            rsp_tready = 1'b0;
            burst_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            burst_left = $urandom_range(0, 13);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      alloc_result_type none;
      int unsigned      bnd_i;
      int unsigned      fp_i;
      int unsigned      pick;
      int unsigned      n_items;
      logic [2:0]       fn;
      logic [15:0]      fp;
      logic [16:0]      cnt;
      logic [16:0]      setting;
      int               p;

      none           = '0;
      mismatch_count = 0;
      result_index   = 0;
      hold_asks      = 0;
      idle_on        = 1'b1;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;

      // predictor state after reset
      frame_map    = '0;
      scan_hint    = '0;
      free_cnt     = '0;
      used_cnt     = '0;
      reserved_cnt = '0;
      total_cfg    = bpfa_pkg::TOTAL_RESET;

      // directed table; typed rows carry their result, the rest use the predictor
      directed_rows = '{
         // counts wrap below zero right after reset
         '{1'b0, 17'd0, bpfa_pkg::FUNC_RESERVE, 16'd5, 17'd1, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd131071, 17'd0, 17'd1}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_FREE, 16'd5, 17'd1, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd0, 17'd131071, 17'd1}},
         // unused codes change nothing
         '{1'b0, 17'd0, FUNC_SPARE6, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd0, 17'd131071, 17'd1}},
         '{1'b0, 17'd0, FUNC_SPARE7, 16'd65535, 17'd131071, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd0, 17'd131071, 17'd1}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_INIT, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd65536, 17'd0, 17'd0}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b1, bpfa_pkg::STATUS_OK, 17'd65535, 17'd1, 17'd0}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b1,
           '{16'd1, 1'b1, bpfa_pkg::STATUS_OK, 17'd65534, 17'd2, 17'd0}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_LOCK, 16'd65535, 17'd1, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd65533, 17'd3, 17'd0}},
         // run leaves the map at the top page
         '{1'b0, 17'd0, bpfa_pkg::FUNC_RESERVE, 16'd65535, 17'd65536, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_RANGE, 17'd65533, 17'd3, 17'd0}},
         // empty run
         '{1'b0, 17'd0, bpfa_pkg::FUNC_FREE, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd65533, 17'd3, 17'd0}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_UNRESERVE, 16'd65535, 17'd1, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd65534, 17'd3, 17'd131071}},
         // whole map in one run
         '{1'b0, 17'd0, bpfa_pkg::FUNC_LOCK, 16'd0, 17'd65536, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd0, 17'd65537, 17'd131071}},
         // nothing free: full scan, hint parks at the bound
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_NOFREE, 17'd0, 17'd65537, 17'd131071}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_FREE, 16'd100, 17'd1, 1'b0, '0},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b0, '0},
         '{1'b1, 17'd0, bpfa_pkg::FUNC_INIT, 16'd0, 17'd0, 1'b0, '0},
         // hint above the bound scans nothing
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_NOFREE, 17'd0, 17'd65537, 17'd131071}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_FREE, 16'd6, 17'd4, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_RANGE, 17'd2, 17'd65535, 17'd131071}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b0, '0},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_INIT, 16'd0, 17'd0, 1'b1,
           '{16'd0, 1'b0, bpfa_pkg::STATUS_OK, 17'd0, 17'd0, 17'd0}},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_REQUEST, 16'd0, 17'd0, 1'b0, '0},
         '{1'b0, 17'd0, bpfa_pkg::FUNC_UNRESERVE, 16'd0, 17'd131071, 1'b0, '0},
         '{1'b1, 17'd65535, bpfa_pkg::FUNC_INIT, 16'd0, 17'd0, 1'b0, '0}
      };

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed part
      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_cfg) begin
            write_total(directed_rows[k].total);
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               repeat ($urandom_range(0, 13)) @(negedge clock);
            end
            offer_op(directed_rows[k].func, directed_rows[k].first,
                     directed_rows[k].count, directed_rows[k].typed,
                     directed_rows[k].want);
         end
      end

      // random phases, each under its own total_pages; phases 2, 5, 8, 11 and the last one have no idling
      for (p = 0; p < 15; p++) begin
         if (p == 0)
            setting = 17'd0;
         else if (p == 1)
            setting = 17'd65536;
         else if (p == 2)
            setting = 17'd65535;
         else begin
            pick = $urandom_range(0, 3);
            if (pick < 2)
               setting = 17'($urandom_range(1, 60));
            else if (pick == 2)
               setting = 17'($urandom_range(61, 4000));
            else
               setting = 17'($urandom_range(0, 65536));
         end
         write_total(setting);
         idle_on = (p != 14) && (p % 3 != 2);

         if ($urandom_range(0, 1) == 1)
            offer_op(bpfa_pkg::FUNC_INIT, 16'($urandom), 17'($urandom_range(0, 131071)),
                     1'b0, none);

         // long receiver hold-off while the sender keeps offering
         if (p == 4) begin
            hold_asks++;
            repeat (12)
               offer_op(($urandom_range(0, 1) == 1) ? bpfa_pkg::FUNC_REQUEST
                                                    : bpfa_pkg::FUNC_LOCK,
                        16'($urandom_range(0, 255)), 17'd1, 1'b0, none);
            wait_all_results();
         end

         n_items = (p == 14) ? 130 : 110;
         repeat (n_items) begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               repeat ($urandom_range(0, 13)) @(negedge clock);
            end
            bnd_i = 32'(map_bound());

            // operation mix: requests dominate, init is rare (it clears the whole map)
            pick = $urandom_range(0, 99);
            if (pick < 34)
               fn = bpfa_pkg::FUNC_REQUEST;
            else if (pick < 50)
               fn = bpfa_pkg::FUNC_FREE;
            else if (pick < 64)
               fn = bpfa_pkg::FUNC_LOCK;
            else if (pick < 76)
               fn = bpfa_pkg::FUNC_RESERVE;
            else if (pick < 88)
               fn = bpfa_pkg::FUNC_UNRESERVE;
            else if (pick < 90)
               fn = bpfa_pkg::FUNC_INIT;
            else if (pick < 95)
               fn = ($urandom_range(0, 1) == 1) ? FUNC_SPARE6 : FUNC_SPARE7;
            else
               fn = bpfa_pkg::FUNC_REQUEST;

            // first page: mostly a working window, some near the bound, some anywhere
            pick = $urandom_range(0, 9);
            if (pick < 7)
               fp_i = (bnd_i <= 256) ? $urandom_range(0, bnd_i + 7) : $urandom_range(0, 255);
            else if (pick < 9)
               fp_i = bnd_i - 1 - $urandom_range(0, 7);
            else
               fp_i = $urandom_range(0, 65535);
            fp = 16'(fp_i);

            // long runs only where the bound cuts them short
            if (fp_i >= bnd_i || bnd_i - fp_i <= 64)
               cnt = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                                 : 17'($urandom_range(0, 16));
            else
               cnt = ($urandom_range(0, 9) == 0) ? 17'd0 : 17'($urandom_range(1, 12));

            offer_op(fn, fp, cnt, 1'b0, none);
         end
      end

      wait_all_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
